[hdl/btmr_pkg.sv]
// shared types, register offsets and bit positions of the bus countdown timer
package btmr_pkg;

  // register byte offsets on the bus
  localparam logic [3:0] ADDR_STATUS   = 4'h0;
  localparam logic [3:0] ADDR_CONTROL  = 4'h4;
  localparam logic [3:0] ADDR_PERIOD   = 4'h8;
  localparam logic [3:0] ADDR_SNAPSHOT = 4'hc;

  // write masks
  localparam logic [15:0] STATUS_WMASK  = 16'hfffd;
  localparam logic [15:0] CONTROL_WMASK = 16'hffff;

  // bit positions
  localparam int RUN_BIT      = 1;
  localparam int IEN_BIT      = 0;
  localparam int PERIODIC_BIT = 1;
  localparam int START_BIT    = 2;
  localparam int STOP_BIT     = 3;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // one request, last field in the lowest bit
  typedef struct packed {
    logic [31:0] write_data;
    logic [3:0]  address;
    logic        write_enable;
    logic        bus_valid;
    logic        sync_reset;
  } item_t;

  // one result, last field in the lowest bit
  typedef struct packed {
    logic        interrupt;
    logic [31:0] read_data;
    logic        ack;
  } result_t;

endpackage

[hdl/btmr_core.sv]
// timer registers, bus write/read decode and the interrupt check for one request
module btmr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  btmr_pkg::item_t  item,
  output btmr_pkg::result_t res
);
  import btmr_pkg::*;

  logic [15:0] status_r, status_nxt;
  logic [15:0] control_r, control_nxt;
  logic [15:0] period_r, period_nxt;
  logic [31:0] count_r, count_nxt;

  logic [15:0] st_w, ctl_w, per_w;
  logic [31:0] cnt_w;
  logic        irq;
  logic        do_write;

  // decrement, then a reset request or the bus write, then the interrupt check
  always_comb begin
    st_w     = status_r;
    ctl_w    = control_r;
    per_w    = period_r;
    cnt_w    = status_r[RUN_BIT] ? count_r - 32'd1 : count_r;
    do_write = item.bus_valid & item.write_enable;
    if (item.sync_reset) begin
      st_w  = '0;
      ctl_w = '0;
      per_w = '0;
      cnt_w = '0;
    end else if (do_write) begin
      case (item.address)
        ADDR_STATUS: begin
          st_w = (status_r & ~STATUS_WMASK) | (item.write_data[15:0] & STATUS_WMASK);
        end
        ADDR_CONTROL: begin
          ctl_w = (control_r & ~CONTROL_WMASK) | (item.write_data[15:0] & CONTROL_WMASK);
          // start wins over stop
          if (item.write_data[START_BIT]) begin
            st_w[RUN_BIT] = 1'b1;
          end else if (item.write_data[STOP_BIT]) begin
            st_w[RUN_BIT] = 1'b0;
          end
        end
        ADDR_PERIOD: begin
          per_w = item.write_data[15:0];
          cnt_w = {16'h0, item.write_data[15:0]};
        end
        default: begin
        end
      endcase
    end

    irq         = ctl_w[IEN_BIT] & st_w[RUN_BIT] & (cnt_w == 32'd0);
    status_nxt  = st_w;
    control_nxt = ctl_w;
    period_nxt  = per_w;
    count_nxt   = cnt_w;
    // reload, and stop in one-shot mode
    if (irq) begin
      count_nxt = {16'h0, per_w};
      if (!ctl_w[PERIODIC_BIT]) begin
        status_nxt[RUN_BIT] = 1'b0;
      end
    end
  end

  // read answer from the updated registers
  always_comb begin
    res.ack       = item.bus_valid & ~item.write_enable;
    res.interrupt = irq;
    res.read_data = '0;
    if (res.ack) begin
      case (item.address)
        ADDR_STATUS:   res.read_data = {16'h0, status_nxt};
        ADDR_CONTROL:  res.read_data = {16'h0, control_nxt};
        ADDR_PERIOD:   res.read_data = {16'h0, period_nxt};
        ADDR_SNAPSHOT: res.read_data = count_nxt;
        default:       res.read_data = '0;
      endcase
    end
  end

  // state registers, updated once per consumed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= '0;
      control_r <= '0;
      period_r  <= '0;
      count_r   <= '0;
    end else if (step) begin
      status_r  <= status_nxt;
      control_r <= control_nxt;
      period_r  <= period_nxt;
      count_r   <= count_nxt;
    end
  end

  // an interrupt reloads the count from the period
  a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.interrupt |=> count_r == {16'h0, period_r})
    else $error("count not reloaded after interrupt");

  // a one-shot interrupt stops the timer
  a_oneshot_stop: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.interrupt && !control_nxt[PERIODIC_BIT] |=> !status_r[RUN_BIT])
    else $error("one-shot interrupt left the timer running");

  // a reset request clears every register
  a_sync_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.sync_reset |=> status_r == '0 && control_r == '0 &&
                                 period_r == '0 && count_r == '0)
    else $error("reset request left state behind");

  // no request, no change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(count_r) && $stable(status_r))
    else $error("state changed without a request");

endmodule

[hdl/bus_countdown_timer.sv]
// Bus countdown timer: each request on the input stream is one timer tick with an
// optional register access (status, control, period, count snapshot).
// Input stream in_*: one request per accepted beat; tdata fields from bit 0 up are
// sync_reset, bus_valid, write_enable, address[3:0], write_data[31:0].
// Output stream out_*: exactly one result per request, in order; tdata fields from
// bit 0 up are ack, read_data[31:0], interrupt.
// A request accepted into the input register is processed when it moves on into the
// result register, which raises out_tvalid; a stall on out_tready can hold it in
// the input register before that.
// Throughput: one request per cycle unless out_tready stalls; the timer state update
// is a single pass of logic between the input register and the result register.
// A stall on out_tready holds the result register and the request waiting in the
// input register; the timer state only advances when a request is processed, so stalls
// never lose or repeat a tick. in_tready falls once both registers are full and stalled.
// rst_n clears the timer registers and empties both stages.
module bus_countdown_timer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sync_reset, bus_valid, write_enable, address[3:0], write_data[31:0], zero pad
  input  logic [btmr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ack, read_data[31:0], interrupt, zero pad
  output logic [btmr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import btmr_pkg::*;

  logic    in_valid_r, in_valid_nxt;
  item_t   item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  result_t res;
  logic    step;
  logic    in_take;

  // request moves into the result register when there is room
  assign step      = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | step;
  assign in_take   = in_tvalid & in_tready;

  always_comb begin
    in_valid_nxt  = in_take | (in_valid_r & ~step);
    out_valid_nxt = step | (out_valid_r & ~out_tready);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_tdata[$bits(item_t)-1:0];
    end
  end

  btmr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_r};

endmodule

[tb/sv/tb_bus_countdown_timer.sv]
// self-checking testbench for the bus countdown timer stream wrapper
`timescale 1ns / 1ps

module tb_bus_countdown_timer;
  import btmr_pkg::*;

  // control register bits as write data
  localparam logic [31:0] CTL_IEN      = 32'd1 << IEN_BIT;
  localparam logic [31:0] CTL_PERIODIC = 32'd1 << PERIODIC_BIT;
  localparam logic [31:0] CTL_START    = 32'd1 << START_BIT;
  localparam logic [31:0] CTL_STOP     = 32'd1 << STOP_BIT;

  localparam int RANDOM_ITEMS = 1250;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    item_t rq;
    bit    drain;
  } pend_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bus_countdown_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // timer state mirrored by the predictor
  logic [15:0] tmr_status;
  logic [15:0] tmr_control;
  logic [15:0] tmr_period;
  logic [31:0] tmr_count;

  pend_t   pending[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      send_gap = 0;
  int      send_steady = 0;
  int      recv_steady = 0;
  int      hold_left = 0;
  bit      long_hold_done = 1'b0;
  bit      drain_next = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // one timer tick with its optional bus access
  function automatic result_t timer_tick(item_t rq);
    result_t res;
    res = '0;
    if (rq.sync_reset) begin
      tmr_status = '0;
      tmr_control = '0;
      tmr_period = '0;
      tmr_count = '0;
    end else begin
      if (tmr_status[RUN_BIT]) tmr_count = tmr_count - 32'd1;
      if (rq.bus_valid && rq.write_enable) begin
        case (rq.address)
          ADDR_STATUS: begin
            tmr_status = (tmr_status & ~STATUS_WMASK) | (rq.write_data[15:0] & STATUS_WMASK);
          end
          ADDR_CONTROL: begin
            tmr_control = rq.write_data[15:0] & CONTROL_WMASK;
            // start wins over stop
            if (rq.write_data[START_BIT]) tmr_status[RUN_BIT] = 1'b1;
            else if (rq.write_data[STOP_BIT]) tmr_status[RUN_BIT] = 1'b0;
          end
          ADDR_PERIOD: begin
            tmr_period = rq.write_data[15:0];
            tmr_count = {16'h0, tmr_period};
          end
          default: ;
        endcase
      end
    end
    // terminal count: reload, one-shot also stops
    if (tmr_control[IEN_BIT] && tmr_status[RUN_BIT] && tmr_count == 32'd0) begin
      res.interrupt = 1'b1;
      tmr_count = {16'h0, tmr_period};
      if (!tmr_control[PERIODIC_BIT]) tmr_status[RUN_BIT] = 1'b0;
    end
    if (rq.bus_valid && !rq.write_enable) begin
      res.ack = 1'b1;
      case (rq.address)
        ADDR_STATUS:   res.read_data = {16'h0, tmr_status};
        ADDR_CONTROL:  res.read_data = {16'h0, tmr_control};
        ADDR_PERIOD:   res.read_data = {16'h0, tmr_period};
        ADDR_SNAPSHOT: res.read_data = tmr_count;
        default:       res.read_data = '0;
      endcase
    end
    return res;
  endfunction

  // idle length: mostly short, a few long, with stretches of none
  function automatic int gap_len(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady = $urandom_range(30, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // request builders
  task automatic put(bit sr, bit v, bit we, logic [3:0] a, logic [31:0] d);
    pend_t p;
    p.rq = '{write_data: d, address: a, write_enable: we, bus_valid: v, sync_reset: sr};
    p.drain = drain_next;
    drain_next = 1'b0;
    pending.push_back(p);
  endtask

  task automatic wr(logic [3:0] a, logic [31:0] d);
    put(1'b0, 1'b1, 1'b1, a, d);
  endtask

  task automatic rd(logic [3:0] a);
    put(1'b0, 1'b1, 1'b0, a, $urandom);
  endtask

  task automatic idle_tick();
    put(1'b0, 1'b0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
  endtask

  function automatic logic [3:0] pick_reg();
    case ($urandom_range(0, 3))
      0:       return ADDR_STATUS;
      1:       return ADDR_CONTROL;
      2:       return ADDR_PERIOD;
      default: return ADDR_SNAPSHOT;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    pend_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(timer_tick(item_t'(in_tdata[$bits(item_t)-1:0])));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && expected_results.size() > 0)) begin
          nxt = pending.pop_front();
          in_tdata <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, nxt.rq};
          in_tvalid <= 1'b1;
          send_gap <= gap_len(send_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (results_seen >= 400 && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      g = gap_len(recv_steady);
      if (g > 0) begin
        hold_left <= g - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", got.read_data, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.ack != want.ack)
          report_mismatch("ack", 32'(got.ack), 32'(want.ack));
        if (got.read_data != want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.interrupt != want.interrupt)
          report_mismatch("interrupt", 32'(got.interrupt), 32'(want.interrupt));
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int n_directed;
    int steps;
    int r;
    bit mid_drain;
    logic [31:0] d;

    tmr_status = '0;
    tmr_control = '0;
    tmr_period = '0;
    tmr_count = '0;
    mid_drain = 1'b0;

    // reset cycle carrying a read, then reset values
    put(1'b1, 1'b1, 1'b0, ADDR_STATUS, 32'hffff_ffff);
    rd(ADDR_CONTROL);
    rd(ADDR_SNAPSHOT);
    // running bit protected in status
    wr(ADDR_STATUS, 32'hffff_ffff);
    rd(ADDR_STATUS);
    wr(ADDR_STATUS, 32'h0);
    // snapshot is read-only
    wr(ADDR_SNAPSHOT, 32'hffff_ffff);
    rd(ADDR_SNAPSHOT);
    // unaligned offsets
    wr(4'h5, 32'hffff_ffff);
    rd(4'h6);
    rd(4'hf);
    idle_tick();
    // zero period: one-shot fires at once and stops
    wr(ADDR_PERIOD, 32'h0);
    wr(ADDR_CONTROL, CTL_IEN | CTL_START);
    rd(ADDR_STATUS);
    // start and stop together, periodic reload
    wr(ADDR_PERIOD, 32'h2);
    wr(ADDR_CONTROL, CTL_IEN | CTL_PERIODIC | CTL_START | CTL_STOP);
    repeat (4) rd(ADDR_SNAPSHOT);
    wr(ADDR_CONTROL, CTL_STOP);
    // count wraps below zero with interrupts off
    wr(ADDR_PERIOD, 32'h0);
    wr(ADDR_CONTROL, CTL_START);
    rd(ADDR_SNAPSHOT);
    wr(ADDR_PERIOD, 32'hffff_ffff);
    rd(ADDR_PERIOD);
    wr(ADDR_CONTROL, 32'hffff_ffff);
    wr(ADDR_CONTROL, CTL_STOP);
    n_directed = pending.size();

    // random part: mostly timer programs, some noise and resets
    drain_next = 1'b1;
    while (pending.size() < n_directed + RANDOM_ITEMS) begin
      if (!mid_drain && pending.size() > n_directed + RANDOM_ITEMS / 2) begin
        mid_drain = 1'b1;
        drain_next = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        d = $urandom;
        if ($urandom_range(0, 9) != 0) d[31:0] = {d[31:16], 16'($urandom_range(0, 12))};
        wr(ADDR_PERIOD, d);
        d = $urandom;
        d[IEN_BIT] = ($urandom_range(0, 9) != 0);
        d[PERIODIC_BIT] = 1'($urandom_range(0, 1));
        d[START_BIT] = ($urandom_range(0, 9) < 8);
        d[STOP_BIT] = 1'($urandom_range(0, 1));
        wr(ADDR_CONTROL, d);
        steps = $urandom_range(3, 30);
        repeat (steps) begin
          r = $urandom_range(0, 99);
          d = $urandom;
          if (r < 40) idle_tick();
          else if (r < 80) rd(pick_reg());
          else if (r < 90) wr(ADDR_STATUS, d);
          else if (r < 95) begin
            d[START_BIT] = 1'($urandom_range(0, 1));
            d[STOP_BIT] = 1'b1;
            wr(ADDR_CONTROL, d);
          end else begin
            if ($urandom_range(0, 3) != 0) d[15:0] = 16'($urandom_range(0, 12));
            wr(ADDR_PERIOD, d);
          end
        end
      end else if (r < 95) begin
        put(($urandom_range(0, 49) == 0), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
      end else begin
        put(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            4'($urandom_range(0, 15)), $urandom);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || in_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
